### rtl/bst_pkg.sv
package bst_pkg;

    // fixed field widths of the request and response beats
    localparam int KEY_W   = 32;
    localparam int RANK_W  = 6;
    localparam int COUNT_W = 6;
    localparam int CAP_W   = 6;

    // reset value of the capacity register
    localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

    typedef enum logic [1:0] {
        MODE_INSERT   = 2'd0,
        MODE_ERASE    = 2'd1,
        MODE_CONTAINS = 2'd2,
        MODE_GET      = 2'd3
    } bst_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_GET,
        ST_SHIFT_UP,
        ST_SHIFT_DN,
        ST_PUT,
        ST_FINISH
    } bst_state_t;

endpackage

### rtl/bst_req_if.sv
interface bst_req_if
    import bst_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic [KEY_W-1:0]  key_value;
    logic [RANK_W-1:0] rank_index;

    modport source (output valid, output mode, output key_value, output rank_index,
                    input ready);
    modport sink   (input valid, input mode, input key_value, input rank_index,
                    output ready);
endinterface

### rtl/bst_rsp_if.sv
interface bst_rsp_if
    import bst_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               ok;
    logic [KEY_W-1:0]   value_out;
    logic [COUNT_W-1:0] count;
    logic               is_empty;

    modport source (output valid, output ok, output value_out, output count,
                    output is_empty, input ready);
    modport sink   (input valid, input ok, input value_out, input count,
                    input is_empty, output ready);
endinterface

### rtl/bst_ram.sv
module bst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/bounded_set_table_top.sv
// channel | dir | fields                             | beat when
// --------+-----+------------------------------------+--------------------
// req     | in  | mode, key_value, rank_index        | req.valid & req.ready
// rsp     | out | ok, value_out, count, is_empty     | rsp.valid & rsp.ready
// cfg     | in  | cfg_wr_data (capacity_limit)       | cfg_wr_en
//
// scan: insert, erase and contains walk the sorted store with the single
//   comparator one entry a cycle; insert and erase then move entries
//   through the one ram write port
// reset: rst_n clears count to zero and capacity to 32; the store is not cleared
// stalls: req.ready is high only in idle; finish holds while the response
//   register is still full, and a finished result waits there while the next
//   request is already taken in
module bounded_set_table_top
    import bst_pkg::*;
#(
    parameter int CAPACITY    = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    bst_req_if.sink          req,
    bst_rsp_if.source        rsp,
    input  logic             cfg_wr_en,
    input  logic [CAP_W-1:0] cfg_wr_data
);

    // stored width: keys are cut to VALUE_WIDTH, and never wider than the port
    localparam int KW   = (VALUE_WIDTH < KEY_W) ? VALUE_WIDTH : KEY_W;
    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int LW   = (CW > CAP_W) ? CW : CAP_W;
    localparam int RW   = (AW > RANK_W) ? AW : RANK_W;
    localparam int CMPW = (CW > RANK_W) ? CW : RANK_W;

    bst_state_t       state_reg, state_next;
    bst_mode_t        mode_reg, mode_next;
    logic [KW-1:0]    key_reg, key_next;
    logic [CW-1:0]    ptr_reg, ptr_next;
    logic [CW-1:0]    pos_reg, pos_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             ok_reg, ok_next;
    logic [KW-1:0]    val_reg, val_next;
    logic [CAP_W-1:0] cap_reg;

    logic               rsp_valid_reg, rsp_valid_next;
    logic               rsp_ok_reg, rsp_ok_next;
    logic [KEY_W-1:0]   rsp_val_reg, rsp_val_next;
    logic [COUNT_W-1:0] rsp_count_reg, rsp_count_next;
    logic               rsp_empty_reg, rsp_empty_next;

    // ram port
    logic          ram_we;
    logic [CW-1:0] ram_waddr;
    logic [KW-1:0] ram_wdata;
    logic [CW-1:0] ram_raddr;
    logic [KW-1:0] ram_rdata;

    // shared compare of the scanned entry against the key
    logic scan_in, scan_lt, scan_eq;
    logic room;
    logic rank_ok;
    logic accept;
    logic rsp_free;
    logic [LW-1:0] cap_wide, cap_max, limit, count_wide;
    logic [RW-1:0] rank_wide;

    assign accept   = req.valid && req.ready;
    assign rsp_free = !rsp_valid_reg || rsp.ready;

    assign scan_in = ptr_reg < count_reg;
    assign scan_lt = scan_in && (ram_rdata < key_reg);
    assign scan_eq = scan_in && (ram_rdata == key_reg);

    // effective capacity, clamped to the built depth
    assign cap_wide   = LW'(cap_reg);
    assign cap_max    = LW'(CAPACITY);
    assign limit      = (cap_wide > cap_max) ? cap_max : cap_wide;
    assign count_wide = LW'(count_reg);
    assign room       = count_wide < limit;

    assign rank_ok   = CMPW'(req.rank_index) < CMPW'(count_reg);
    assign rank_wide = RW'(req.rank_index);

    bst_ram #(
        .WIDTH (KW),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr[AW-1:0]),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr[AW-1:0]),
        .rd_data (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (bst_mode_t'(req.mode) == MODE_GET)
                    begin
                        state_next = rank_ok ? ST_GET : ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!scan_lt)
                begin
                    unique case (mode_reg)
                        MODE_INSERT:
                        begin
                            if (scan_eq || !room)
                            begin
                                state_next = ST_FINISH;
                            end
                            else if (ptr_reg == count_reg)
                            begin
                                state_next = ST_PUT;
                            end
                            else
                            begin
                                state_next = ST_SHIFT_UP;
                            end
                        end
                        MODE_ERASE:
                        begin
                            if (scan_eq && (ptr_reg + CW'(1) != count_reg))
                            begin
                                state_next = ST_SHIFT_DN;
                            end
                            else
                            begin
                                state_next = ST_FINISH;
                            end
                        end
                        MODE_CONTAINS, MODE_GET:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_GET:
            begin
                state_next = ST_FINISH;
            end
            ST_SHIFT_UP:
            begin
                if (ptr_reg - CW'(1) == pos_reg)
                begin
                    state_next = ST_PUT;
                end
            end
            ST_SHIFT_DN:
            begin
                if (ptr_reg + CW'(2) == count_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_PUT:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and ram control
    always_comb
    begin
        mode_next  = mode_reg;
        key_next   = key_reg;
        ptr_next   = ptr_reg;
        pos_next   = pos_reg;
        count_next = count_reg;
        ok_next    = ok_reg;
        val_next   = val_reg;
        ram_we     = 1'b0;
        ram_waddr  = ptr_reg;
        ram_wdata  = ram_rdata;
        ram_raddr  = ptr_reg;

        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_ok_next    = rsp_ok_reg;
        rsp_val_next   = rsp_val_reg;
        rsp_count_next = rsp_count_reg;
        rsp_empty_next = rsp_empty_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                ram_raddr = '0;
                if (accept)
                begin
                    mode_next = bst_mode_t'(req.mode);
                    key_next  = req.key_value[KW-1:0];
                    ptr_next  = '0;
                    ok_next   = 1'b0;
                    val_next  = '0;
                    if (bst_mode_t'(req.mode) == MODE_GET)
                    begin
                        ram_raddr = CW'(rank_wide[AW-1:0]);
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_lt)
                begin
                    ptr_next  = ptr_reg + CW'(1);
                    ram_raddr = ptr_reg + CW'(1);
                end
                else
                begin
                    pos_next = ptr_reg;
                    unique case (mode_reg)
                        MODE_INSERT:
                        begin
                            // open a gap from the top down, first read the last entry
                            ptr_next  = count_reg;
                            ram_raddr = count_reg - CW'(1);
                        end
                        MODE_ERASE:
                        begin
                            ok_next   = scan_eq;
                            ram_raddr = ptr_reg + CW'(1);
                            if (scan_eq && (ptr_reg + CW'(1) == count_reg))
                            begin
                                // last entry goes, nothing to move
                                count_next = count_reg - CW'(1);
                            end
                        end
                        MODE_CONTAINS, MODE_GET:
                        begin
                            ok_next = scan_eq;
                        end
                    endcase
                end
            end
            ST_GET:
            begin
                ok_next  = 1'b1;
                val_next = ram_rdata;
            end
            ST_SHIFT_UP:
            begin
                // entry ptr-1 arrived, move it up one place
                ram_we    = 1'b1;
                ram_waddr = ptr_reg;
                ram_raddr = ptr_reg - CW'(2);
                ptr_next  = ptr_reg - CW'(1);
            end
            ST_SHIFT_DN:
            begin
                // entry ptr+1 arrived, move it down one place
                ram_we    = 1'b1;
                ram_waddr = ptr_reg;
                ram_raddr = ptr_reg + CW'(2);
                ptr_next  = ptr_reg + CW'(1);
                if (ptr_reg + CW'(2) == count_reg)
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            ST_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg;
                ram_wdata  = key_reg;
                ok_next    = 1'b1;
                count_next = count_reg + CW'(1);
            end
            ST_FINISH:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_ok_next    = ok_reg;
                    rsp_val_next   = KEY_W'(val_reg);
                    rsp_count_next = count_wide[COUNT_W-1:0];
                    rsp_empty_next = (count_reg == '0);
                end
            end
            default:
            begin
                ptr_next = '0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        key_reg       <= key_next;
        ptr_reg       <= ptr_next;
        pos_reg       <= pos_next;
        ok_reg        <= ok_next;
        val_reg       <= val_next;
        rsp_ok_reg    <= rsp_ok_next;
        rsp_val_reg   <= rsp_val_next;
        rsp_count_reg <= rsp_count_next;
        rsp_empty_reg <= rsp_empty_next;
    end

    assign req.ready     = (state_reg == ST_IDLE);
    assign rsp.valid     = rsp_valid_reg;
    assign rsp.ok        = rsp_ok_reg;
    assign rsp.value_out = rsp_val_reg;
    assign rsp.count     = rsp_count_reg;
    assign rsp.is_empty  = rsp_empty_reg;

endmodule

### sim/bounded_set_table_top_tb.sv
module bounded_set_table_top_tb;
    import bst_pkg::*;

    // built size of the store and the slowest op (full scan plus shift)
    localparam int SET_DEPTH       = 32;
    localparam int SETTLE_CYCLES   = 40;
    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int KEY_POOL_SIZE   = 40;
    localparam int NUM_DIRECTED    = 24;
    localparam int LONG_HOLD       = 400;

    // one response beat, field for field
    typedef struct packed {
        logic               ok;
        logic [KEY_W-1:0]   value;
        logic [COUNT_W-1:0] count;
        logic               is_empty;
    } set_reply_t;

    // directed row: request plus, where it is obvious, the reply typed in
    typedef struct packed {
        bst_mode_t         op;
        logic [KEY_W-1:0]  key;
        logic [RANK_W-1:0] rank;
        logic              typed;
        set_reply_t        want;
    } directed_row_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CAP_W-1:0] cfg_wr_data;

    bst_req_if req_if();
    bst_rsp_if rsp_if();

    bounded_set_table_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_if),
        .rsp         (rsp_if),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // shadow of the set: sorted values, how many, and the capacity register
    logic [KEY_W-1:0] shadow_vals [SET_DEPTH];
    int               shadow_count = 0;
    int               shadow_cap   = 32;

    set_reply_t set_replies_due [$];
    int         error_count = 0;

    // idling knobs, in percent; the long hold is handed to the receiver
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_request  = 0;
    int hold_left     = 0;

    logic [KEY_W-1:0] key_pool [KEY_POOL_SIZE];

    // capacity plan: reset value, the extremes, above the build, and a
    // drop below the current fill straight after the set has filled up
    logic [CAP_W-1:0] cap_plan [NUM_PHASES] = '{
        6'd32, 6'd1, 6'd0, 6'd63, 6'd5, 6'd33, 6'd2, 6'd32, 6'd17, 6'd40
    };

    // directed part: empty set first, then both key extremes, duplicates,
    // gets in and out of range, and erase of a missing value
    directed_row_t directed_rows [NUM_DIRECTED] = '{
        '{MODE_GET,      32'h0000_0000, 6'd0,  1'b1, '{1'b0, 32'h0, 6'd0, 1'b1}},
        '{MODE_CONTAINS, 32'h0000_0000, 6'd0,  1'b1, '{1'b0, 32'h0, 6'd0, 1'b1}},
        '{MODE_ERASE,    32'h0000_0000, 6'd0,  1'b1, '{1'b0, 32'h0, 6'd0, 1'b1}},
        '{MODE_INSERT,   32'h0000_0000, 6'd0,  1'b1, '{1'b1, 32'h0, 6'd1, 1'b0}},
        '{MODE_INSERT,   32'hFFFF_FFFF, 6'd0,  1'b1, '{1'b1, 32'h0, 6'd2, 1'b0}},
        '{MODE_INSERT,   32'h0000_0000, 6'd0,  1'b1, '{1'b0, 32'h0, 6'd2, 1'b0}},
        '{MODE_GET,      32'h0000_0000, 6'd0,  1'b1, '{1'b1, 32'h0, 6'd2, 1'b0}},
        '{MODE_GET,      32'h0000_0000, 6'd1,  1'b1,
          '{1'b1, 32'hFFFF_FFFF, 6'd2, 1'b0}},
        '{MODE_GET,      32'h0000_0000, 6'd2,  1'b1, '{1'b0, 32'h0, 6'd2, 1'b0}},
        '{MODE_GET,      32'hFFFF_FFFF, 6'd63, 1'b1, '{1'b0, 32'h0, 6'd2, 1'b0}},
        '{MODE_CONTAINS, 32'hFFFF_FFFF, 6'd63, 1'b1, '{1'b1, 32'h0, 6'd2, 1'b0}},
        '{MODE_INSERT,   32'h8000_0000, 6'd0,  1'b1, '{1'b1, 32'h0, 6'd3, 1'b0}},
        '{MODE_INSERT,   32'h7FFF_FFFF, 6'd63, 1'b1, '{1'b1, 32'h0, 6'd4, 1'b0}},
        '{MODE_GET,      32'h0000_0000, 6'd1,  1'b1,
          '{1'b1, 32'h7FFF_FFFF, 6'd4, 1'b0}},
        '{MODE_GET,      32'hFFFF_FFFF, 6'd2,  1'b1,
          '{1'b1, 32'h8000_0000, 6'd4, 1'b0}},
        '{MODE_ERASE,    32'h7FFF_FFFF, 6'd0,  1'b1, '{1'b1, 32'h0, 6'd3, 1'b0}},
        '{MODE_ERASE,    32'h7FFF_FFFF, 6'd0,  1'b1, '{1'b0, 32'h0, 6'd3, 1'b0}},
        '{MODE_CONTAINS, 32'h1234_5678, 6'd0,  1'b0, '{1'b0, 32'h0, 6'd0, 1'b0}},
        '{MODE_INSERT,   32'h5555_5555, 6'd21, 1'b0, '{1'b0, 32'h0, 6'd0, 1'b0}},
        '{MODE_INSERT,   32'hAAAA_AAAA, 6'd42, 1'b0, '{1'b0, 32'h0, 6'd0, 1'b0}},
        '{MODE_GET,      32'h0000_0000, 6'd3,  1'b0, '{1'b0, 32'h0, 6'd0, 1'b0}},
        '{MODE_ERASE,    32'h0000_0000, 6'd0,  1'b0, '{1'b0, 32'h0, 6'd0, 1'b0}},
        '{MODE_ERASE,    32'hFFFF_FFFF, 6'd0,  1'b0, '{1'b0, 32'h0, 6'd0, 1'b0}},
        '{MODE_GET,      32'h0000_0000, 6'd0,  1'b0, '{1'b0, 32'h0, 6'd0, 1'b0}}
    };

    // clock, period 12
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // one line per mismatch
    task automatic report_mismatch(string msg);
        error_count++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    // applies one request to the shadow set and returns the reply it gives
    function automatic set_reply_t apply_set_op(bst_mode_t op, logic [KEY_W-1:0] key,
                                                logic [RANK_W-1:0] rank);
        set_reply_t r;
        int         pos;
        int         lim;
        bit         hit;
        r   = '0;
        lim = (shadow_cap > SET_DEPTH) ? SET_DEPTH : shadow_cap;
        // first slot not below the key, then whether it holds the key
        pos = 0;
        while (pos < shadow_count && shadow_vals[pos] < key)
        begin
            pos++;
        end
        hit = (pos < shadow_count) && (shadow_vals[pos] == key);
        case (op)
            MODE_INSERT:
            begin
                if (!hit && shadow_count < lim)
                begin
                    for (int i = shadow_count; i > pos; i--)
                    begin
                        shadow_vals[i] = shadow_vals[i-1];
                    end
                    shadow_vals[pos] = key;
                    shadow_count++;
                    r.ok = 1'b1;
                end
            end
            MODE_ERASE:
            begin
                if (hit)
                begin
                    for (int i = pos; i < shadow_count - 1; i++)
                    begin
                        shadow_vals[i] = shadow_vals[i+1];
                    end
                    shadow_count--;
                    r.ok = 1'b1;
                end
            end
            MODE_CONTAINS:
            begin
                r.ok = hit;
            end
            default:
            begin
                if (rank < shadow_count)
                begin
                    r.ok    = 1'b1;
                    r.value = shadow_vals[rank];
                end
            end
        endcase
        r.count    = shadow_count[COUNT_W-1:0];
        r.is_empty = (shadow_count == 0);
        return r;
    endfunction

    // offers one request beat, with random gaps first, and returns at the
    // edge where it is taken
    task automatic offer_request(bst_mode_t op, logic [KEY_W-1:0] key,
                                 logic [RANK_W-1:0] rank);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.mode       <= op;
        req_if.key_value  <= key;
        req_if.rank_index <= rank;
        do
        begin
            @(posedge clk);
        end
        while (!req_if.ready);
    endtask

    // stop offering, let every reply out, then let the engine settle
    task automatic wait_drain();
        req_if.valid <= 1'b0;
        while (set_replies_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] cap);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        shadow_cap   = int'(cap);
    endtask

    // receiver: random stalls, plus the long hold counted down here
    initial
    begin
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                rsp_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // reply checker: every beat against the oldest reply still due
    always @(posedge clk)
    begin
        set_reply_t due;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (set_replies_due.size() == 0)
            begin
                report_mismatch("reply beat with no request outstanding");
            end
            else
            begin
                due = set_replies_due.pop_front();
                check_field("ok", KEY_W'(rsp_if.ok), KEY_W'(due.ok));
                check_field("value_out", rsp_if.value_out, due.value);
                check_field("count", KEY_W'(rsp_if.count), KEY_W'(due.count));
                check_field("is_empty", KEY_W'(rsp_if.is_empty), KEY_W'(due.is_empty));
            end
        end
    end

    // main sequence
    initial
    begin : stimulus
        bst_mode_t         op;
        logic [KEY_W-1:0]  key;
        logic [RANK_W-1:0] rank;
        set_reply_t        got;
        int                pick;
        int                rank_top;

        rst_n             <= 1'b0;
        cfg_wr_en         <= 1'b0;
        cfg_wr_data       <= '0;
        req_if.valid      <= 1'b0;
        req_if.mode       <= MODE_INSERT;
        req_if.key_value  <= '0;
        req_if.rank_index <= '0;

        // keys mostly come from a small pool so that they collide; the
        // pool holds both extremes and the two half-range corners
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = 32'h7FFF_FFFF;
        key_pool[4] = 32'h0000_0001;
        for (int i = 5; i < KEY_POOL_SIZE; i++)
        begin
            key_pool[i] = $urandom();
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at the reset capacity, light idling on both sides
        send_idle_pct = 10;
        stall_pct     = 10;
        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            offer_request(directed_rows[i].op, directed_rows[i].key,
                          directed_rows[i].rank);
            got = apply_set_op(directed_rows[i].op, directed_rows[i].key,
                               directed_rows[i].rank);
            set_replies_due.push_back(directed_rows[i].typed ? directed_rows[i].want : got);
        end

        // random phases, each at its own capacity and idling pattern;
        // even phases lean towards insert to fill, odd ones towards erase
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_drain();
            write_capacity(cap_plan[ph]);
            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 80;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 80;
                end
                default:
                begin
                    send_idle_pct = 10;
                    stall_pct     = 10;
                end
            endcase
            // back-pressure: replies held off long enough to stall requests
            if (ph == 0)
            begin
                hold_request = LONG_HOLD;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                pick = $urandom_range(99);
                if (ph % 2 == 0)
                begin
                    op = bst_mode_t'((pick < 45) ? MODE_INSERT :
                                     (pick < 60) ? MODE_ERASE :
                                     (pick < 80) ? MODE_CONTAINS : MODE_GET);
                end
                else
                begin
                    op = bst_mode_t'((pick < 20) ? MODE_INSERT :
                                     (pick < 55) ? MODE_ERASE :
                                     (pick < 75) ? MODE_CONTAINS : MODE_GET);
                end
                if ($urandom_range(99) < 85)
                begin
                    key = key_pool[$urandom_range(KEY_POOL_SIZE-1)];
                end
                else
                begin
                    key = $urandom();
                end
                // ranks mostly up to one past the fill so gets hit the valid edge
                rank_top = (shadow_count + 1 > 63) ? 63 : shadow_count + 1;
                if ($urandom_range(99) < 70)
                begin
                    rank = RANK_W'($urandom_range(rank_top));
                end
                else
                begin
                    rank = RANK_W'($urandom_range(63));
                end
                offer_request(op, key, rank);
                set_replies_due.push_back(apply_set_op(op, key, rank));
            end
        end

        wait_drain();
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #12_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
